// ===== src/fjt_pkg.sv =====
// Shared types and constants for the full text justifier.
`timescale 1ns / 1ps
package fjt_pkg;

  localparam int unsigned CNT_W = 6;   // counts and widths, up to 63
  localparam logic [7:0] SPACE_CH = 8'h20;

  // Classified input character, front to back
  typedef struct packed {
    logic [7:0] ch;
    logic       keep;
    logic       word_end;
    logic       text_end;
  } item_t;

  // One output character
  typedef struct packed {
    logic [7:0] ch;
    logic       line_last;
    logic       text_last;
    logic       truncated;
  } out_t;

endpackage

// ===== src/fjt_fifo.sv =====
// Small synchronous FIFO used between the stages and at the output.
`timescale 1ns / 1ps
module fjt_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wp_r, rp_r;
  logic [AW:0]      cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp_r] <= din;
    end
  end

endmodule

// ===== src/fjt_front.sv =====
// Front end: accepts characters and marks those past the line width for drop.
`timescale 1ns / 1ps
module fjt_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      clr,
  input  logic [fjt_pkg::CNT_W-1:0] w_eff,
  input  logic                      in_push,
  input  logic [7:0]                in_ch,
  input  logic                      in_word_end,
  input  logic                      in_text_end,
  input  logic                      q_full,
  output logic                      q_push,
  output fjt_pkg::item_t            q_item
);

  logic [fjt_pkg::CNT_W-1:0] cur_len_r;
  logic                      keep;

  assign keep          = (cur_len_r < w_eff);
  assign q_push        = in_push && !q_full;
  assign q_item.ch       = in_ch;
  assign q_item.keep     = keep;
  assign q_item.word_end = in_word_end;
  assign q_item.text_end = in_text_end;

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      cur_len_r <= '0;
    end else if (q_push) begin
      if (in_word_end || in_text_end) begin
        cur_len_r <= '0;
      end else if (keep) begin
        cur_len_r <= cur_len_r + 1'b1;
      end
    end
  end

endmodule

// ===== src/fjt_back.sv =====
// Back end: builds, justifies, emits lines, one char a cycle unless stalled.
`timescale 1ns / 1ps
module fjt_back #(
  parameter int unsigned MAX_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      clr,
  input  logic [fjt_pkg::CNT_W-1:0] w_eff,
  input  logic                      q_empty,
  input  fjt_pkg::item_t            q_item,
  output logic                      q_pop,
  input  logic                      out_full,
  output logic                      out_push,
  output fjt_pkg::out_t             out_item
);

  localparam int unsigned IDX_W   = $clog2(MAX_WIDTH);
  localparam int unsigned SLOTS   = (MAX_WIDTH + 1) / 2;
  localparam int unsigned SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW      = fjt_pkg::CNT_W;

  typedef enum logic [2:0] {
    B_IDLE, B_CHECK, B_PREP, B_DIV, B_EMIT, B_COPY
  } state_t;

  state_t state_r;

  logic [7:0]    word_buf [MAX_WIDTH];
  logic [7:0]    line_buf [MAX_WIDTH];
  logic [CW-1:0] len_buf  [SLOTS];

  logic [CW-1:0] cur_len_r, len_r, letters_r, k_r;
  logic [4:0]    count_r, nw_r, gaps_r;
  logic          word_over_r, trunc_r, te_r, final_r;
  logic [CW-1:0] spaces_r, rem_r, quo_r, even_r, extra_r;
  logic [2:0]    dbit_r;
  logic [CW-1:0] wrem_r, grem_r, pos_r, src_r;

  logic [CW-1:0] cur_len_nxt, rem_sh, rem_nxt, quo_nxt;
  logic          div_ge;
  logic [SLOT_AW-1:0] rd_slot;
  logic [CW-1:0] slot_len;
  logic [CW:0]   fit_sum;
  logic          e_last;
  logic [7:0]    e_char;
  logic [CW-1:0] gap_len;
  logic [4:0]    gap_idx;

  always_comb begin
    cur_len_nxt = cur_len_r + CW'(q_item.keep);
    rd_slot     = (state_r == B_PREP) ? '0 : nw_r[SLOT_AW-1:0];
    slot_len    = len_buf[rd_slot];
    fit_sum     = (CW+1)'(letters_r) + (CW+1)'(count_r) + (CW+1)'(len_r);
    rem_sh      = {rem_r[CW-2:0], spaces_r[dbit_r]};
    div_ge      = (rem_sh >= CW'(gaps_r));
    rem_nxt     = div_ge ? rem_sh - CW'(gaps_r) : rem_sh;
    quo_nxt     = quo_r;
    quo_nxt[dbit_r] = div_ge;
    gap_idx     = nw_r - 5'd1;
    gap_len     = even_r + CW'(CW'(gap_idx) < extra_r);
    e_last      = (pos_r == w_eff - 1'b1);
    e_char      = (wrem_r != '0) ? line_buf[src_r[IDX_W-1:0]] : fjt_pkg::SPACE_CH;
    q_pop       = (state_r == B_IDLE) && !q_empty;
    out_push    = (state_r == B_EMIT) && !out_full;
    out_item.ch        = e_char;
    out_item.line_last = e_last;
    out_item.text_last = e_last && final_r;
    out_item.truncated = trunc_r;
  end

  // Control and counters
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      state_r     <= B_IDLE;
      cur_len_r   <= '0;
      letters_r   <= '0;
      count_r     <= '0;
      word_over_r <= 1'b0;
      trunc_r     <= 1'b0;
      final_r     <= 1'b0;
    end else begin
      unique case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            cur_len_r <= cur_len_nxt;
            if (!q_item.keep) begin
              word_over_r <= 1'b1;
            end
            if (q_item.word_end || q_item.text_end) begin
              len_r   <= cur_len_nxt;
              te_r    <= q_item.text_end;
              state_r <= B_CHECK;
            end
          end
        end
        B_CHECK: begin
          k_r <= '0;
          if (count_r != '0 && fit_sum > (CW+1)'(w_eff)) begin
            final_r <= 1'b0;
            state_r <= B_PREP;
          end else begin
            state_r <= B_COPY;
          end
        end
        B_PREP: begin
          wrem_r   <= slot_len;
          nw_r     <= 5'd1;
          grem_r   <= '0;
          pos_r    <= '0;
          src_r    <= '0;
          gaps_r   <= count_r - 5'd1;
          spaces_r <= w_eff - letters_r;
          rem_r    <= '0;
          quo_r    <= '0;
          dbit_r   <= 3'(CW - 1);
          if (final_r || count_r <= 5'd1) begin
            even_r  <= CW'(1);
            extra_r <= '0;
            state_r <= B_EMIT;
          end else begin
            state_r <= B_DIV;
          end
        end
        B_DIV: begin
          rem_r  <= rem_nxt;
          quo_r  <= quo_nxt;
          dbit_r <= dbit_r - 3'd1;
          if (dbit_r == '0) begin
            even_r  <= quo_nxt;
            extra_r <= rem_nxt;
            state_r <= B_EMIT;
          end
        end
        B_EMIT: begin
          if (!out_full) begin
            pos_r <= pos_r + 1'b1;
            if (wrem_r != '0) begin
              src_r  <= src_r + 1'b1;
              wrem_r <= wrem_r - 1'b1;
              if (wrem_r == CW'(1) && nw_r < count_r) begin
                grem_r <= gap_len;
              end
            end else if (grem_r != '0) begin
              grem_r <= grem_r - 1'b1;
              if (grem_r == CW'(1)) begin
                wrem_r <= slot_len;
                nw_r   <= nw_r + 5'd1;
              end
            end
            if (e_last) begin
              letters_r <= '0;
              count_r   <= '0;
              trunc_r   <= 1'b0;
              state_r   <= final_r ? B_IDLE : B_COPY;
            end
          end
        end
        B_COPY: begin
          k_r <= k_r + 1'b1;
          if (k_r == len_r - 1'b1) begin
            letters_r   <= letters_r + len_r;
            count_r     <= count_r + 5'd1;
            trunc_r     <= trunc_r | word_over_r;
            word_over_r <= 1'b0;
            cur_len_r   <= '0;
            if (te_r) begin
              final_r <= 1'b1;
              state_r <= B_PREP;
            end else begin
              state_r <= B_IDLE;
            end
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  // Buffers, no reset
  always_ff @(posedge clk) begin
    if (state_r == B_IDLE && !q_empty && q_item.keep) begin
      word_buf[cur_len_r[IDX_W-1:0]] <= q_item.ch;
    end
    if (state_r == B_COPY) begin
      line_buf[IDX_W'(letters_r + k_r)] <= word_buf[k_r[IDX_W-1:0]];
      if (k_r == len_r - 1'b1) begin
        len_buf[count_r[SLOT_AW-1:0]] <= len_r;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 5'(SLOTS))
    else $error("line word count over slot count");

  a_letters_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (CW+1)'(letters_r) + (CW+1)'(count_r) <= (CW+1)'(w_eff) + 1'b1)
    else $error("open line exceeds width");

  a_emit_pos: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_EMIT |-> pos_r < w_eff)
    else $error("emit position past line width");

endmodule

// ===== src/full_text_justifier.sv =====
// Top level of the greedy full text justifier.
//
// Input: one character per push (in_ch, in_word_end, in_text_end),
// accepted when in_push is high and in_full is low. A front stage counts
// characters per word and marks those past the line width for drop; a
// four-entry queue hands them to the back stage.
// Output: one line character per pop (out_char, out_line_last, out_text_last,
// out_truncated), valid while out_empty is low. Every line is exactly the
// effective width long; out_text_last marks the end of the text.
// Config: cfg_line_width written on cfg_valid (cfg_ready is always high);
// the user writes it only while idle (the block does not enforce this); it
// clears front and back state, not the queues. 0 acts as 1, above MAX_WIDTH
// acts as MAX_WIDTH. Reset value is 32. Sequence: the back stage takes in
// each character of a word, runs the word-end fit check, copies the word
// into the line character by character, and emits a justified line through
// setup, a 6-step restoring divide for the gap split, then one character per
// cycle while the output queue has room; a single-word or final line skips
// the divide. The back does not take input while emitting. A stalled
// receiver fills the two-entry output queue, halts emission, then the inner
// queue, then in_full. Reset clears the queues and the back-stage state.
`timescale 1ns / 1ps
module full_text_justifier #(
  parameter int unsigned MAX_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_ch,
  input  logic       in_word_end,
  input  logic       in_text_end,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_char,
  output logic       out_line_last,
  output logic       out_text_last,
  output logic       out_truncated,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [5:0] cfg_line_width
);

  localparam int unsigned CW = fjt_pkg::CNT_W;

  logic [CW-1:0] width_r, w_eff;
  logic          clr;

  fjt_pkg::item_t fq_in, fq_out;
  logic           fq_push, fq_full, fq_pop, fq_empty;
  fjt_pkg::out_t  oq_in, oq_out;
  logic           oq_push, oq_full;

  assign cfg_ready = 1'b1;
  assign clr       = cfg_valid;

  // Effective width, clamped to 1..MAX_WIDTH
  always_comb begin
    priority if (width_r == '0) begin
      w_eff = CW'(1);
    end else if (width_r > CW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= CW'(32);
    end else if (cfg_valid) begin
      width_r <= cfg_line_width;
    end
  end

  fjt_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .clr         (clr),
    .w_eff       (w_eff),
    .in_push     (in_push),
    .in_ch       (in_ch),
    .in_word_end (in_word_end),
    .in_text_end (in_text_end),
    .q_full      (fq_full),
    .q_push      (fq_push),
    .q_item      (fq_in)
  );

  assign in_full = fq_full;

  fjt_fifo #(.WIDTH($bits(fjt_pkg::item_t)), .DEPTH(4)) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fq_push),
    .din   (fq_in),
    .full  (fq_full),
    .pop   (fq_pop),
    .dout  (fq_out),
    .empty (fq_empty)
  );

  fjt_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr      (clr),
    .w_eff    (w_eff),
    .q_empty  (fq_empty),
    .q_item   (fq_out),
    .q_pop    (fq_pop),
    .out_full (oq_full),
    .out_push (oq_push),
    .out_item (oq_in)
  );

  fjt_fifo #(.WIDTH($bits(fjt_pkg::out_t)), .DEPTH(2)) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (oq_push),
    .din   (oq_in),
    .full  (oq_full),
    .pop   (out_pop),
    .dout  (oq_out),
    .empty (out_empty)
  );

  assign out_char      = oq_out.ch;
  assign out_line_last = oq_out.line_last;
  assign out_text_last = oq_out.text_last;
  assign out_truncated = oq_out.truncated;

endmodule
